// File: rtl/eqc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqc_pkg
// Shared widths, types and the arctangent table for the Euler to quaternion
// converter.
// ----------------------------------------------------------------------------
package eqc_pkg;

   // CORDIC x/y in Q2.30 with headroom, residual angle in 2^40 per turn
   localparam int CW = 34;
   localparam int ZW = 42;
   // t = floor(a*b / 2^30), triple product, part sum
   localparam int TW = 2 * CW - 30;
   localparam int PW = TW + CW;
   localparam int SW = PW + 1;
   localparam int AXES = 3;
   localparam int MAX_STAGES = 32;

   localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

   typedef logic signed [CW-1:0] cval_type;
   typedef logic signed [ZW-1:0] zval_type;

   // one beat between CORDIC cells: three axes in parallel
   typedef struct packed {
      cval_type [AXES-1:0] x;
      cval_type [AXES-1:0] y;
      zval_type [AXES-1:0] z;
   } cordic_type;

   // sine/cosine of the three half angles
   typedef struct packed {
      cval_type [AXES-1:0] c;
      cval_type [AXES-1:0] s;
   } trig_type;

   // atan(2^-i) in turns, scaled by 2^40
   function automatic zval_type atan_step(input int idx);
      logic [31:0] t32;
      case (idx)
         0:  t32 = 32'd536870912;
         1:  t32 = 32'd316933406;
         2:  t32 = 32'd167458907;
         3:  t32 = 32'd85004756;
         4:  t32 = 32'd42667331;
         5:  t32 = 32'd21354465;
         6:  t32 = 32'd10679838;
         7:  t32 = 32'd5340245;
         8:  t32 = 32'd2670163;
         9:  t32 = 32'd1335087;
         10: t32 = 32'd667544;
         11: t32 = 32'd333772;
         12: t32 = 32'd166886;
         13: t32 = 32'd83443;
         14: t32 = 32'd41722;
         15: t32 = 32'd20861;
         16: t32 = 32'd10430;
         17: t32 = 32'd5215;
         18: t32 = 32'd2608;
         19: t32 = 32'd1304;
         20: t32 = 32'd652;
         21: t32 = 32'd326;
         22: t32 = 32'd163;
         23: t32 = 32'd81;
         24: t32 = 32'd41;
         25: t32 = 32'd20;
         26: t32 = 32'd10;
         27: t32 = 32'd5;
         28: t32 = 32'd3;
         29: t32 = 32'd1;
         30: t32 = 32'd1;
         default: t32 = 32'd0;
      endcase
      atan_step = zval_type'({t32, 8'd0});
   endfunction

endpackage

// File: rtl/euler_to_quaternion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_to_quaternion
// XYZ Euler angles (binary angles) to unit quaternion, Q1.(OUT_BITS-1).
// ----------------------------------------------------------------------------
//  channel  direction  beat contents
//  req_     in         angle_x, angle_y, angle_z
//  rsp_     out        quat_w, quat_x, quat_y, quat_z
//
// One beat per cycle sustained while rsp_ready is held high. The stages are
// one cell per CORDIC iteration, then pair product, triple product and the
// round/saturate output register. Every stage holds its own valid, so a
// stalled result only blocks the stages behind it once they fill up.
// Synchronous reset clears all valid bits; payload is not reset.
// ----------------------------------------------------------------------------
module euler_to_quaternion #(
   parameter int ANGLE_BITS    = 16,
   parameter int OUT_BITS      = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [ANGLE_BITS-1:0] req_angle_x,
   input  logic signed [ANGLE_BITS-1:0] req_angle_y,
   input  logic signed [ANGLE_BITS-1:0] req_angle_z,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [OUT_BITS-1:0]   rsp_quat_w,
   output logic signed [OUT_BITS-1:0]   rsp_quat_x,
   output logic signed [OUT_BITS-1:0]   rsp_quat_y,
   output logic signed [OUT_BITS-1:0]   rsp_quat_z
);

   localparam int NS = (CORDIC_STAGES < eqc_pkg::MAX_STAGES) ?
                       CORDIC_STAGES : eqc_pkg::MAX_STAGES;
   localparam int ZSH = 39 - ANGLE_BITS;

   logic                chain_valid [NS+1];
   logic                chain_ready [NS+1];
   eqc_pkg::cordic_type chain_data  [NS+1];
   eqc_pkg::trig_type   trig;

   // seed: half angle as residual, x at CORDIC gain, y at zero
   always_comb begin
      chain_data[0].x = {eqc_pkg::AXES{eqc_pkg::GAIN_Q30}};
      chain_data[0].y = '0;
      chain_data[0].z[0] = eqc_pkg::zval_type'(req_angle_x) <<< ZSH;
      chain_data[0].z[1] = eqc_pkg::zval_type'(req_angle_y) <<< ZSH;
      chain_data[0].z[2] = eqc_pkg::zval_type'(req_angle_z) <<< ZSH;
   end
   assign chain_valid[0] = req_valid;
   assign req_ready      = chain_ready[0];

   // row of CORDIC cells
   for (genvar g = 0; g < NS; g++) begin : g_cell
      eqc_cordic_cell #(
         .STAGE (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[g]),
         .in_ready  (chain_ready[g]),
         .in_data   (chain_data[g]),
         .out_valid (chain_valid[g+1]),
         .out_ready (chain_ready[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   assign trig.c = chain_data[NS].x;
   assign trig.s = chain_data[NS].y;

   eqc_quat #(
      .OUT_BITS (OUT_BITS)
   ) u_quat (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[NS]),
      .in_ready  (chain_ready[NS]),
      .in_data   (trig),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .quat_w    (rsp_quat_w),
      .quat_x    (rsp_quat_x),
      .quat_y    (rsp_quat_y),
      .quat_z    (rsp_quat_z)
   );

   // nothing comes out of an empty pipe
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // with the output register empty the whole chain must take beats
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("input stalled while output empty");

   // a stalled result is not dropped by the stage logic
   assert property (@(posedge clock) disable iff (reset)
                    rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("stalled result lost");

endmodule

// File: rtl/eqc_cordic_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqc_cordic_cell
// One rotation-mode CORDIC iteration for all three axes, with its own
// valid/ready stage register.
// ----------------------------------------------------------------------------
module eqc_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  eqc_pkg::cordic_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output eqc_pkg::cordic_type out_data
);

   localparam eqc_pkg::zval_type DA = eqc_pkg::atan_step(STAGE);

   logic                valid_ff;
   eqc_pkg::cordic_type data_ff;
   eqc_pkg::cordic_type data_in;

   // stage can load when empty or when its beat leaves
   assign in_ready = !valid_ff || out_ready;

   // micro-rotation, direction from sign of residual
   always_comb begin
      for (int a = 0; a < eqc_pkg::AXES; a++) begin
         if (!in_data.z[a][eqc_pkg::ZW-1]) begin
            data_in.x[a] = in_data.x[a] - (in_data.y[a] >>> STAGE);
            data_in.y[a] = in_data.y[a] + (in_data.x[a] >>> STAGE);
            data_in.z[a] = in_data.z[a] - DA;
         end else begin
            data_in.x[a] = in_data.x[a] + (in_data.y[a] >>> STAGE);
            data_in.y[a] = in_data.y[a] - (in_data.x[a] >>> STAGE);
            data_in.z[a] = in_data.z[a] + DA;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: rtl/eqc_quat.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eqc_quat
// Quaternion parts from half-angle sines and cosines: pair products,
// triple products, then add, round and saturate. Three stage registers.
// ----------------------------------------------------------------------------
module eqc_quat #(
   parameter int OUT_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  eqc_pkg::trig_type          in_data,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic signed [OUT_BITS-1:0] quat_w,
   output logic signed [OUT_BITS-1:0] quat_x,
   output logic signed [OUT_BITS-1:0] quat_y,
   output logic signed [OUT_BITS-1:0] quat_z
);

   localparam int TW = eqc_pkg::TW;
   localparam int PW = eqc_pkg::PW;
   localparam int SW = eqc_pkg::SW;
   localparam int SH = 61 - OUT_BITS;
   localparam logic signed [SW-1:0] HALF = SW'(1) <<< (SH - 1);
   localparam logic signed [SW-1:0] HI   = (SW'(1) <<< (OUT_BITS - 1)) - SW'(1);
   localparam logic signed [SW-1:0] LO   = -(SW'(1) <<< (OUT_BITS - 1));

   // stage A: pair products cx*cy, sx*sy, sx*cy, cx*sy
   logic                        va_ff;
   logic                        rdy_a;
   logic signed [TW-1:0]        t_cc_ff, t_ss_ff, t_sc_ff, t_cs_ff;
   logic signed [TW-1:0]        t_cc_in, t_ss_in, t_sc_in, t_cs_in;
   eqc_pkg::cval_type           cz_ff, sz_ff;
   // stage B: eight triple products
   logic                        vb_ff;
   logic                        rdy_b;
   logic signed [PW-1:0]        p_ff [8];
   logic signed [PW-1:0]        p_in [8];
   // stage C: output register
   logic                        vc_ff;
   logic                        rdy_c;
   logic signed [OUT_BITS-1:0]  q_ff [4];
   logic signed [OUT_BITS-1:0]  q_in [4];
   logic signed [SW-1:0]        sum [4];

   assign rdy_c    = !vc_ff || out_ready;
   assign rdy_b    = !vb_ff || rdy_c;
   assign rdy_a    = !va_ff || rdy_b;
   assign in_ready = rdy_a;

   // pair products, floor to Q30
   always_comb begin
      logic signed [2*eqc_pkg::CW-1:0] m_cc, m_ss, m_sc, m_cs;
      m_cc = in_data.c[0] * in_data.c[1];
      m_ss = in_data.s[0] * in_data.s[1];
      m_sc = in_data.s[0] * in_data.c[1];
      m_cs = in_data.c[0] * in_data.s[1];
      t_cc_in = TW'(m_cc >>> 30);
      t_ss_in = TW'(m_ss >>> 30);
      t_sc_in = TW'(m_sc >>> 30);
      t_cs_in = TW'(m_cs >>> 30);
   end

   // triple products
   always_comb begin
      p_in[0] = t_cc_ff * PW'(cz_ff);  // w
      p_in[1] = t_ss_ff * PW'(sz_ff);  // w
      p_in[2] = t_sc_ff * PW'(cz_ff);  // x
      p_in[3] = t_cs_ff * PW'(sz_ff);  // x
      p_in[4] = t_cs_ff * PW'(cz_ff);  // y
      p_in[5] = t_sc_ff * PW'(sz_ff);  // y
      p_in[6] = t_cc_ff * PW'(sz_ff);  // z
      p_in[7] = t_ss_ff * PW'(cz_ff);  // z
   end

   // part sums, round half up, saturate
   always_comb begin
      logic signed [SW-1:0] r;
      sum[0] = SW'(p_ff[0]) + SW'(p_ff[1]);
      sum[1] = SW'(p_ff[2]) - SW'(p_ff[3]);
      sum[2] = SW'(p_ff[4]) + SW'(p_ff[5]);
      sum[3] = SW'(p_ff[6]) - SW'(p_ff[7]);
      r = '0;
      for (int k = 0; k < 4; k++) begin
         r = (sum[k] + HALF) >>> SH;
         if (r > HI) begin
            q_in[k] = OUT_BITS'(HI);
         end else if (r < LO) begin
            q_in[k] = OUT_BITS'(LO);
         end else begin
            q_in[k] = OUT_BITS'(r);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         if (rdy_a) begin
            va_ff <= in_valid;
         end
         if (rdy_b) begin
            vb_ff <= va_ff;
         end
         if (rdy_c) begin
            vc_ff <= vb_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy_a && in_valid) begin
         t_cc_ff <= t_cc_in;
         t_ss_ff <= t_ss_in;
         t_sc_ff <= t_sc_in;
         t_cs_ff <= t_cs_in;
         cz_ff   <= in_data.c[2];
         sz_ff   <= in_data.s[2];
      end
      if (rdy_b && va_ff) begin
         for (int k = 0; k < 8; k++) begin
            p_ff[k] <= p_in[k];
         end
      end
      if (rdy_c && vb_ff) begin
         for (int k = 0; k < 4; k++) begin
            q_ff[k] <= q_in[k];
         end
      end
   end

   assign out_valid = vc_ff;
   assign quat_w    = q_ff[0];
   assign quat_x    = q_ff[1];
   assign quat_y    = q_ff[2];
   assign quat_z    = q_ff[3];

endmodule

// File: bench/tb_euler_to_quaternion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euler_to_quaternion
// Streams angle triples into the converter and checks every quaternion beat
// against a bit-exact CORDIC and triple-product predictor.
// ----------------------------------------------------------------------------
module tb_euler_to_quaternion;

   localparam int ANGLE_BITS = 16;
   localparam int OUT_BITS   = 16;
   localparam int STAGES     = 16;
   localparam int LATENCY    = STAGES + 3;
   localparam int WATCHDOG   = 2000;
   localparam int N_RANDOM   = 1100;

   typedef logic signed [ANGLE_BITS-1:0] angle_type;
   typedef logic signed [OUT_BITS-1:0]   part_type;

   typedef struct packed {
      angle_type ax;
      angle_type ay;
      angle_type az;
   } euler_type;

   typedef struct packed {
      part_type w;
      part_type x;
      part_type y;
      part_type z;
   } quat_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_ready;
   angle_type req_angle_x = '0;
   angle_type req_angle_y = '0;
   angle_type req_angle_z = '0;
   logic      rsp_valid;
   logic      rsp_ready = 1'b0;
   part_type  rsp_quat_w, rsp_quat_x, rsp_quat_y, rsp_quat_z;

   euler_type pending_angles[$];
   quat_type  expected_quats[$];
   int        mismatch_count = 0;
   int        idle_cycles = 0;
   bit        stimulus_done = 1'b0;
   int        send_wait = 0;
   int        recv_wait = 0;
   int        hold_off = 0;
   int        beats_sent = 0;

   euler_to_quaternion #(
      .ANGLE_BITS(ANGLE_BITS), .OUT_BITS(OUT_BITS), .CORDIC_STAGES(STAGES)
   ) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_angle_x(req_angle_x), .req_angle_y(req_angle_y),
      .req_angle_z(req_angle_z),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_quat_w(rsp_quat_w), .rsp_quat_x(rsp_quat_x),
      .rsp_quat_y(rsp_quat_y), .rsp_quat_z(rsp_quat_z)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // atan(2^-i) in turns, 2^40 per turn
   function automatic longint arctan_turns(int i);
      longint tbl[32] = '{536870912, 316933406, 167458907, 85004756,
         42667331, 21354465, 10679838, 5340245, 2670163, 1335087, 667544,
         333772, 166886, 83443, 41722, 20861, 10430, 5215, 2608, 1304, 652,
         326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0};
      return tbl[i] * 256;
   endfunction

   // sine and cosine of the half angle, Q2.30
   function automatic void half_angle_trig(input angle_type a, output longint s,
                                           output longint c);
      longint zr, xr, yr, dx, dy;
      zr = longint'(a) * (longint'(1) << (39 - ANGLE_BITS));
      xr = 652032874;
      yr = 0;
      for (int i = 0; i < STAGES; i++) begin
         dx = yr >>> i;
         dy = xr >>> i;
         if (zr >= 0) begin
            xr -= dx; yr += dy; zr -= arctan_turns(i);
         end else begin
            xr += dx; yr -= dy; zr += arctan_turns(i);
         end
      end
      s = yr;
      c = xr;
   endfunction

   function automatic longint triple_q60(longint a, longint b, longint c);
      return ((a * b) >>> 30) * c;
   endfunction

   // round half up and saturate to Q1.(OUT_BITS-1)
   function automatic part_type round_sat(longint q60);
      longint r;
      int sh;
      sh = 61 - OUT_BITS;
      r = (q60 + (longint'(1) << (sh - 1))) >>> sh;
      if (r > (longint'(1) << (OUT_BITS - 1)) - 1) r = (longint'(1) << (OUT_BITS - 1)) - 1;
      if (r < -(longint'(1) << (OUT_BITS - 1))) r = -(longint'(1) << (OUT_BITS - 1));
      return part_type'(r);
   endfunction

   function automatic quat_type euler_to_quat(euler_type e);
      longint sx, cx, sy, cy, sz, cz;
      quat_type q;
      half_angle_trig(e.ax, sx, cx);
      half_angle_trig(e.ay, sy, cy);
      half_angle_trig(e.az, sz, cz);
      q.w = round_sat(triple_q60(cx, cy, cz) + triple_q60(sx, sy, sz));
      q.x = round_sat(triple_q60(sx, cy, cz) - triple_q60(cx, sy, sz));
      q.y = round_sat(triple_q60(cx, sy, cz) + triple_q60(sx, cy, sz));
      q.z = round_sat(triple_q60(cx, cy, sz) - triple_q60(sx, sy, cz));
      return q;
   endfunction

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      mismatch_count++;
   endtask

   function automatic angle_type pick_angle();
      case ($urandom_range(0, 5))
         0: return angle_type'(16'sh8000);
         1: return angle_type'(16'sh7fff);
         2: return angle_type'($urandom_range(0, 8) - 4);
         3: return angle_type'({$urandom_range(0, 7), 13'd0});
         default: return angle_type'($urandom);
      endcase
   endfunction

   // stimulus: corners first, then random triples
   initial begin
      angle_type corners[8] = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'sh0001,
                                16'shffff, 16'sh4000, 16'shc000, 16'sh2000};
      euler_type e;
      for (int i = 0; i < 8; i++) begin
         pending_angles.push_back('{corners[i], corners[i], corners[i]});
         pending_angles.push_back('{corners[i], corners[(i + 3) % 8], corners[(i + 5) % 8]});
      end
      for (int i = 0; i < N_RANDOM; i++) begin
         e.ax = pick_angle();
         e.ay = pick_angle();
         e.az = pick_angle();
         pending_angles.push_back(e);
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) beats_sent <= beats_sent + 1;
         if (req_valid && !req_ready) begin
            // hold the beat
         end else if (send_wait > 0) begin
            req_valid <= 1'b0;
            send_wait <= send_wait - 1;
         end else if (pending_angles.size() > 0) begin
            e_push();
         end else begin
            req_valid <= 1'b0;
            stimulus_done <= 1'b1;
         end
      end
   end

   task automatic e_push();
      euler_type e;
      e = pending_angles.pop_front();
      req_valid <= 1'b1;
      req_angle_x <= e.ax;
      req_angle_y <= e.ay;
      req_angle_z <= e.az;
      expected_quats.push_back(euler_to_quat(e));
      // mostly back-to-back, sometimes a gap after this beat
      send_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 14) : 0;
   endtask

   // receiver: random stalls plus one long hold-off while the sender runs on
   always @(posedge clock) begin
      if (!reset) begin
         if (beats_sent == 300 && hold_off == 0) begin
            hold_off <= 200;
            rsp_ready <= 1'b0;
         end else if (hold_off > 1) begin
            hold_off <= hold_off - 1;
         end else if (hold_off == 1) begin
            hold_off <= -1;
            rsp_ready <= 1'b1;
         end else if (rsp_valid && rsp_ready) begin
            recv_wait <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 14) : 0;
            rsp_ready <= 1'b0;
         end else if (recv_wait > 0) begin
            recv_wait <= recv_wait - 1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      quat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_quats.size() == 0) begin
            $display("MISMATCH unexpected result beat");
            mismatch_count++;
         end else begin
            want = expected_quats.pop_front();
            if (rsp_quat_w !== want.w) report_mismatch("quat_w", rsp_quat_w, want.w);
            if (rsp_quat_x !== want.x) report_mismatch("quat_x", rsp_quat_x, want.x);
            if (rsp_quat_y !== want.y) report_mismatch("quat_y", rsp_quat_y, want.y);
            if (rsp_quat_z !== want.z) report_mismatch("quat_z", rsp_quat_z, want.z);
         end
      end
   end

   // watchdog on cycles with no beat on either channel
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      wait (stimulus_done && expected_quats.size() == 0);
      repeat (LATENCY + 5) @(posedge clock);
      if (mismatch_count == 0 && expected_quats.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
